/* rtl/scr_pkg.sv */
// Shared types, constants and helpers for the sphere contact resolver.
package scr_pkg;

    localparam int WORD_BITS = 32;
    localparam int REST_BITS = 17;
    localparam int VAL_BITS  = 64;

    // Magnitude ceiling applied to the scaled products and to every quotient.
    localparam logic [VAL_BITS-1:0] CAP = 64'h4000_0000_0000_0000;

    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    typedef struct packed {
        logic                        command;
        logic signed [WORD_BITS-1:0] pos_x;
        logic signed [WORD_BITS-1:0] pos_y;
        logic signed [WORD_BITS-1:0] pos_z;
        logic signed [WORD_BITS-1:0] vel_x;
        logic signed [WORD_BITS-1:0] vel_y;
        logic signed [WORD_BITS-1:0] vel_z;
        logic [WORD_BITS-1:0]        inv_mass;
        logic [WORD_BITS-1:0]        radius;
        logic [REST_BITS-1:0]        restitution;
    } item_in_t;

    typedef struct packed {
        logic                        body_slot;
        logic signed [WORD_BITS-1:0] new_pos_x;
        logic signed [WORD_BITS-1:0] new_pos_y;
        logic signed [WORD_BITS-1:0] new_pos_z;
        logic signed [WORD_BITS-1:0] new_vel_x;
        logic signed [WORD_BITS-1:0] new_vel_y;
        logic signed [WORD_BITS-1:0] new_vel_z;
        logic                        last;
    } item_out_t;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_rsp_t;

    function automatic logic [VAL_BITS-1:0] sat_cap(input logic [2*VAL_BITS-1:0] v);
        logic [VAL_BITS-1:0] r;
        begin
            if (v > {{VAL_BITS{1'b0}}, CAP})
                r = CAP;
            else
                r = v[VAL_BITS-1:0];
            return r;
        end
    endfunction

    function automatic logic signed [WORD_BITS-1:0] sat_word(input logic signed [VAL_BITS-1:0] v);
        logic signed [VAL_BITS-1:0]  hi;
        logic signed [VAL_BITS-1:0]  lo;
        logic signed [WORD_BITS-1:0] r;
        begin
            hi = {{(VAL_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
            lo = {{(VAL_BITS-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};
            if (v > hi)
                r = hi[WORD_BITS-1:0];
            else if (v < lo)
                r = lo[WORD_BITS-1:0];
            else
                r = v[WORD_BITS-1:0];
            return r;
        end
    endfunction

endpackage

/* rtl/scr_arith_unit.sv */
// Shared multi-cycle multiplier, fractional divider and square root around one adder.
module scr_arith_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  scr_pkg::unit_req_t    req,
    input  logic [63:0]           opa,
    input  logic [63:0]           opb,
    output scr_pkg::unit_rsp_t    rsp,
    output logic [127:0]          res
);

    localparam logic [7:0] MUL_STEPS  = 8'd64;
    localparam logic [7:0] DIV_STEPS  = 8'(64 + FRAC_BITS);
    localparam logic [7:0] ROOT_STEPS = 8'd64;

    logic [1:0]   op_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [7:0]   cnt_reg;
    logic [67:0]  x_reg;
    logic [127:0] w_reg;
    logic [63:0]  q_reg;
    logic [63:0]  b_reg;
    logic         ovf_reg;

    logic [67:0]  add_a;
    logic [67:0]  add_b;
    logic         add_cin;
    logic [68:0]  add_sum;
    logic         carry;

    // One adder serves all three operations; subtraction is a + ~b + 1.
    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        case (op_reg)
            scr_pkg::OP_MUL:
            begin
                add_a = {4'b0, x_reg[63:0]};
                add_b = w_reg[0] ? {4'b0, b_reg} : 68'd0;
            end
            scr_pkg::OP_DIV:
            begin
                add_a   = {3'b0, x_reg[63:0], w_reg[127]};
                add_b   = ~{4'b0, b_reg};
                add_cin = 1'b1;
            end
            scr_pkg::OP_SQRT:
            begin
                add_a   = {x_reg[65:0], w_reg[127:126]};
                add_b   = ~{2'b0, q_reg, 2'b01};
                add_cin = 1'b1;
            end
            default:
            begin
                add_a = '0;
            end
        endcase
        add_sum = {1'b0, add_a} + {1'b0, add_b} + {68'd0, add_cin};
        carry   = add_sum[68];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= scr_pkg::OP_MUL;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 8'd1);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
            end
            else if (busy_reg && (cnt_reg == 8'd1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg   <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
            b_reg   <= opb;
            case (req.op)
                scr_pkg::OP_MUL:
                begin
                    w_reg   <= {64'd0, opa};
                    cnt_reg <= MUL_STEPS;
                end
                scr_pkg::OP_DIV:
                begin
                    w_reg   <= {opa, 64'd0};
                    cnt_reg <= DIV_STEPS;
                end
                default:
                begin
                    w_reg   <= {opb, opa};
                    cnt_reg <= ROOT_STEPS;
                end
            endcase
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 8'd1;
            case (op_reg)
                scr_pkg::OP_MUL:
                begin
                    x_reg <= {4'b0, add_sum[64:1]};
                    w_reg <= {w_reg[127:64], add_sum[0], w_reg[63:1]};
                end
                scr_pkg::OP_DIV:
                begin
                    x_reg   <= carry ? add_sum[67:0] : add_a;
                    w_reg   <= {w_reg[126:0], 1'b0};
                    q_reg   <= {q_reg[62:0], carry};
                    ovf_reg <= ovf_reg | q_reg[63];
                end
                default:
                begin
                    x_reg <= carry ? add_sum[67:0] : add_a;
                    w_reg <= {w_reg[125:0], 2'b00};
                    q_reg <= {q_reg[62:0], carry};
                end
            endcase
        end
    end

    always_comb
    begin
        rsp.busy = busy_reg;
        rsp.done = done_reg;
        case (op_reg)
            scr_pkg::OP_MUL:
            begin
                res = {x_reg[63:0], w_reg[63:0]};
            end
            scr_pkg::OP_DIV:
            begin
                res = {64'd0, (ovf_reg || (q_reg > scr_pkg::CAP)) ? scr_pkg::CAP : q_reg};
            end
            default:
            begin
                res = {64'd0, q_reg};
            end
        endcase
    end

endmodule

/* rtl/sphere_contact_resolve.sv */
// Top level of the sphere contact resolver: holding registers, sequencer and result port.
//
// Usage: items enter on in_valid/in_ready and results leave on out_valid/out_ready.
// An item with command 0 stores body A and gives no result.
// An item with command 1 brings body B. With a body held, two result items follow:
// body A (body_slot 0), then body B (body_slot 1, last 1). Without a held body the
// item is dropped. in_ready is high only while the block is idle.
// All multiplies, divides and square roots run on one shared unit (64-step multiply,
// 64+FRAC_BITS-step divide, 64-step square root).
// A resolving item runs longest when the spheres overlap and approach, and shortest
// when the centers coincide or both bodies are immovable.
// Reset clears the sequencer and the held-body flag; nothing else needs clearing.
// A stalled receiver holds the current result in place and the block waits,
// accepting no new item until body B has been taken.
module sphere_contact_resolve #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  scr_pkg::item_in_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output scr_pkg::item_out_t   out_data
);

    localparam int WB = scr_pkg::WORD_BITS;
    localparam int VB = scr_pkg::VAL_BITS;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_SQ    = 5'd1;
    localparam logic [4:0] ST_CHECK = 5'd2;
    localparam logic [4:0] ST_ROOT  = 5'd3;
    localparam logic [4:0] ST_NORM  = 5'd4;
    localparam logic [4:0] ST_PEN   = 5'd5;
    localparam logic [4:0] ST_SDIV  = 5'd6;
    localparam logic [4:0] ST_CPOS  = 5'd7;
    localparam logic [4:0] ST_APOS  = 5'd8;
    localparam logic [4:0] ST_BPOS  = 5'd9;
    localparam logic [4:0] ST_CLOS  = 5'd10;
    localparam logic [4:0] ST_CTEST = 5'd11;
    localparam logic [4:0] ST_JMUL  = 5'd12;
    localparam logic [4:0] ST_JDIV  = 5'd13;
    localparam logic [4:0] ST_TVEL  = 5'd14;
    localparam logic [4:0] ST_AVEL  = 5'd15;
    localparam logic [4:0] ST_BVEL  = 5'd16;
    localparam logic [4:0] ST_OUTA  = 5'd17;
    localparam logic [4:0] ST_OUTB  = 5'd18;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       issued_reg;
    logic       issued_next;
    logic       held_valid_reg;
    logic       held_valid_next;

    logic signed [WB-1:0] held_pos_reg [3];
    logic signed [WB-1:0] held_vel_reg [3];
    logic [WB-1:0]        held_im_reg;
    logic [WB-1:0]        held_rad_reg;
    logic [scr_pkg::REST_BITS-1:0] held_rest_reg;

    logic signed [VB-1:0] apos_reg [3];
    logic signed [VB-1:0] bpos_reg [3];
    logic signed [VB-1:0] avel_reg [3];
    logic signed [VB-1:0] bvel_reg [3];
    logic signed [WB:0]   d_reg [3];
    logic signed [VB-1:0] n_reg [3];
    logic [WB-1:0]        aim_reg;
    logic [WB-1:0]        bim_reg;
    logic [WB:0]          inv_sum_reg;
    logic [WB:0]          rad_sum_reg;
    logic [17:0]          e_reg;
    logic [2*WB+3:0]      lensq_reg;
    logic [WB+1:0]        dist_reg;
    logic [VB-2:0]        k_reg;
    logic signed [VB-1:0] tmp_reg;
    logic signed [VB-1:0] closing_reg;

    scr_pkg::unit_req_t u_req;
    scr_pkg::unit_rsp_t u_rsp;
    logic [63:0]        u_a;
    logic [63:0]        u_b;
    logic [127:0]       u_res;
    logic [1:0]         u_op;
    logic               u_go;
    logic               u_neg;

    logic                 in_acc;
    logic                 out_acc;
    logic signed [WB:0]   d_sel;
    logic signed [VB-1:0] n_sel;
    logic signed [VB-1:0] vdiff;
    logic signed [WB+2:0] pen;
    logic [VB-1:0]        prod_mag;
    logic signed [VB-1:0] smul_val;
    logic signed [VB-1:0] div_val;
    logic [VB-1:0]        jn_val;
    logic [scr_pkg::REST_BITS-1:0] rest_max;

    function automatic logic [63:0] mag64(input logic signed [VB-1:0] v);
        begin
            return v[VB-1] ? 64'(-v) : 64'(v);
        end
    endfunction

    function automatic logic signed [VB-1:0] sx(input logic signed [WB-1:0] v);
        begin
            return {{(VB-WB){v[WB-1]}}, v};
        end
    endfunction

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUTA) || (state_reg == ST_OUTB);

    assign rest_max = (held_rest_reg > in_data.restitution) ? held_rest_reg
                                                            : in_data.restitution;

    always_comb
    begin
        d_sel = d_reg[idx_reg];
        n_sel = n_reg[idx_reg];
        vdiff = avel_reg[idx_reg] - bvel_reg[idx_reg];
        pen   = $signed({2'b0, rad_sum_reg}) - $signed({1'b0, dist_reg});
        u_op  = scr_pkg::OP_MUL;
        u_a   = '0;
        u_b   = '0;
        u_go  = 1'b0;
        u_neg = 1'b0;
        case (state_reg)
            ST_SQ:
            begin
                u_go = 1'b1;
                u_a  = mag64({{(VB-WB-1){d_sel[WB]}}, d_sel});
                u_b  = u_a;
            end
            ST_ROOT:
            begin
                u_go = 1'b1;
                u_op = scr_pkg::OP_SQRT;
                u_a  = lensq_reg[63:0];
                u_b  = 64'(lensq_reg[2*WB+3:64]);
            end
            ST_NORM:
            begin
                u_go  = 1'b1;
                u_op  = scr_pkg::OP_DIV;
                u_a   = mag64({{(VB-WB-1){d_sel[WB]}}, d_sel});
                u_b   = 64'(dist_reg);
                u_neg = d_sel[WB];
            end
            ST_SDIV, ST_JDIV:
            begin
                u_go = 1'b1;
                u_op = scr_pkg::OP_DIV;
                u_a  = {1'b0, k_reg};
                u_b  = 64'(inv_sum_reg);
            end
            ST_CPOS, ST_TVEL:
            begin
                u_go  = 1'b1;
                u_a   = mag64(n_sel);
                u_b   = {1'b0, k_reg};
                u_neg = n_sel[VB-1];
            end
            ST_APOS, ST_AVEL:
            begin
                u_go  = 1'b1;
                u_a   = mag64(tmp_reg);
                u_b   = 64'(aim_reg);
                u_neg = tmp_reg[VB-1];
            end
            ST_BPOS, ST_BVEL:
            begin
                u_go  = 1'b1;
                u_a   = mag64(tmp_reg);
                u_b   = 64'(bim_reg);
                u_neg = tmp_reg[VB-1];
            end
            ST_CLOS:
            begin
                u_go  = 1'b1;
                u_a   = mag64(vdiff);
                u_b   = mag64(n_sel);
                u_neg = vdiff[VB-1] ^ n_sel[VB-1];
            end
            ST_JMUL:
            begin
                u_go = 1'b1;
                u_a  = mag64(closing_reg);
                u_b  = 64'(e_reg);
            end
            default:
            begin
                u_go = 1'b0;
            end
        endcase
        u_req.start = u_go && !issued_reg;
        u_req.op    = u_op;

        prod_mag = scr_pkg::sat_cap(u_res >> FRAC_BITS);
        smul_val = u_neg ? -$signed(prod_mag) : $signed(prod_mag);
        div_val  = u_neg ? -$signed(u_res[63:0]) : $signed(u_res[63:0]);
        jn_val   = scr_pkg::sat_cap(u_res >> 16);
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        issued_next     = issued_reg;
        held_valid_next = held_valid_reg;
        if (u_req.start)
            issued_next = 1'b1;
        if (u_rsp.done)
            issued_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (!in_data.command)
                        held_valid_next = 1'b1;
                    else if (held_valid_reg)
                    begin
                        held_valid_next = 1'b0;
                        state_next      = ST_SQ;
                        idx_next        = 2'd0;
                    end
                end
            end
            ST_SQ, ST_NORM, ST_CLOS:
            begin
                if (u_rsp.done)
                begin
                    idx_next = (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                    if (idx_reg == 2'd2)
                    begin
                        case (state_reg)
                            ST_SQ:   state_next = ST_CHECK;
                            ST_NORM: state_next = ST_PEN;
                            default: state_next = ST_CTEST;
                        endcase
                    end
                end
            end
            ST_CHECK:
            begin
                if ((lensq_reg == '0) || (inv_sum_reg == '0))
                    state_next = ST_OUTA;
                else
                    state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (u_rsp.done)
                    state_next = ST_NORM;
            end
            ST_PEN:
            begin
                state_next = (pen > 0) ? ST_SDIV : ST_CLOS;
            end
            ST_SDIV:
            begin
                if (u_rsp.done)
                    state_next = ST_CPOS;
            end
            ST_CPOS:
            begin
                if (u_rsp.done)
                    state_next = ST_APOS;
            end
            ST_APOS:
            begin
                if (u_rsp.done)
                    state_next = ST_BPOS;
            end
            ST_BPOS:
            begin
                if (u_rsp.done)
                begin
                    idx_next   = (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                    state_next = (idx_reg == 2'd2) ? ST_CLOS : ST_CPOS;
                end
            end
            ST_CTEST:
            begin
                state_next = closing_reg[VB-1] ? ST_JMUL : ST_OUTA;
            end
            ST_JMUL:
            begin
                if (u_rsp.done)
                    state_next = ST_JDIV;
            end
            ST_JDIV:
            begin
                if (u_rsp.done)
                    state_next = ST_TVEL;
            end
            ST_TVEL:
            begin
                if (u_rsp.done)
                    state_next = ST_AVEL;
            end
            ST_AVEL:
            begin
                if (u_rsp.done)
                    state_next = ST_BVEL;
            end
            ST_BVEL:
            begin
                if (u_rsp.done)
                begin
                    idx_next   = (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                    state_next = (idx_reg == 2'd2) ? ST_OUTA : ST_TVEL;
                end
            end
            ST_OUTA:
            begin
                if (out_acc)
                    state_next = ST_OUTB;
            end
            ST_OUTB:
            begin
                if (out_acc)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= 2'd0;
            issued_reg     <= 1'b0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            issued_reg     <= issued_next;
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && !in_data.command)
                begin
                    held_pos_reg[0] <= in_data.pos_x;
                    held_pos_reg[1] <= in_data.pos_y;
                    held_pos_reg[2] <= in_data.pos_z;
                    held_vel_reg[0] <= in_data.vel_x;
                    held_vel_reg[1] <= in_data.vel_y;
                    held_vel_reg[2] <= in_data.vel_z;
                    held_im_reg     <= in_data.inv_mass;
                    held_rad_reg    <= in_data.radius;
                    held_rest_reg   <= in_data.restitution;
                end
                else if (in_acc)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        apos_reg[i] <= sx(held_pos_reg[i]);
                        avel_reg[i] <= sx(held_vel_reg[i]);
                    end
                    bpos_reg[0] <= sx(in_data.pos_x);
                    bpos_reg[1] <= sx(in_data.pos_y);
                    bpos_reg[2] <= sx(in_data.pos_z);
                    bvel_reg[0] <= sx(in_data.vel_x);
                    bvel_reg[1] <= sx(in_data.vel_y);
                    bvel_reg[2] <= sx(in_data.vel_z);
                    d_reg[0] <= {held_pos_reg[0][WB-1], held_pos_reg[0]}
                                - {in_data.pos_x[WB-1], in_data.pos_x};
                    d_reg[1] <= {held_pos_reg[1][WB-1], held_pos_reg[1]}
                                - {in_data.pos_y[WB-1], in_data.pos_y};
                    d_reg[2] <= {held_pos_reg[2][WB-1], held_pos_reg[2]}
                                - {in_data.pos_z[WB-1], in_data.pos_z};
                    aim_reg     <= held_im_reg;
                    bim_reg     <= in_data.inv_mass;
                    inv_sum_reg <= {1'b0, held_im_reg} + {1'b0, in_data.inv_mass};
                    rad_sum_reg <= {1'b0, held_rad_reg} + {1'b0, in_data.radius};
                    e_reg       <= 18'd65536 + {1'b0, rest_max};
                    lensq_reg   <= '0;
                    closing_reg <= '0;
                end
            end
            ST_SQ:
            begin
                if (u_rsp.done)
                    lensq_reg <= lensq_reg + u_res[2*WB+3:0];
            end
            ST_ROOT:
            begin
                if (u_rsp.done)
                    dist_reg <= u_res[WB+1:0];
            end
            ST_NORM:
            begin
                if (u_rsp.done)
                    n_reg[idx_reg] <= div_val;
            end
            ST_PEN:
            begin
                k_reg <= (VB-1)'(pen[WB+1:0]);
            end
            ST_SDIV, ST_JDIV:
            begin
                if (u_rsp.done)
                    k_reg <= u_res[VB-2:0];
            end
            ST_CPOS, ST_TVEL:
            begin
                if (u_rsp.done)
                    tmp_reg <= smul_val;
            end
            ST_APOS:
            begin
                if (u_rsp.done)
                    apos_reg[idx_reg] <= apos_reg[idx_reg] + smul_val;
            end
            ST_BPOS:
            begin
                if (u_rsp.done)
                    bpos_reg[idx_reg] <= bpos_reg[idx_reg] - smul_val;
            end
            ST_AVEL:
            begin
                if (u_rsp.done)
                    avel_reg[idx_reg] <= avel_reg[idx_reg] + smul_val;
            end
            ST_BVEL:
            begin
                if (u_rsp.done)
                    bvel_reg[idx_reg] <= bvel_reg[idx_reg] - smul_val;
            end
            ST_CLOS:
            begin
                if (u_rsp.done)
                    closing_reg <= closing_reg + smul_val;
            end
            ST_JMUL:
            begin
                if (u_rsp.done)
                    k_reg <= jn_val[VB-2:0];
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

    scr_arith_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (u_req),
        .opa   (u_a),
        .opb   (u_b),
        .rsp   (u_rsp),
        .res   (u_res)
    );

    always_comb
    begin
        if (state_reg == ST_OUTB)
        begin
            out_data.new_pos_x = scr_pkg::sat_word(bpos_reg[0]);
            out_data.new_pos_y = scr_pkg::sat_word(bpos_reg[1]);
            out_data.new_pos_z = scr_pkg::sat_word(bpos_reg[2]);
            out_data.new_vel_x = scr_pkg::sat_word(bvel_reg[0]);
            out_data.new_vel_y = scr_pkg::sat_word(bvel_reg[1]);
            out_data.new_vel_z = scr_pkg::sat_word(bvel_reg[2]);
        end
        else
        begin
            out_data.new_pos_x = scr_pkg::sat_word(apos_reg[0]);
            out_data.new_pos_y = scr_pkg::sat_word(apos_reg[1]);
            out_data.new_pos_z = scr_pkg::sat_word(apos_reg[2]);
            out_data.new_vel_x = scr_pkg::sat_word(avel_reg[0]);
            out_data.new_vel_y = scr_pkg::sat_word(avel_reg[1]);
            out_data.new_vel_z = scr_pkg::sat_word(avel_reg[2]);
        end
        out_data.body_slot = (state_reg == ST_OUTB);
        out_data.last      = (state_reg == ST_OUTB);
    end

    // Body B always follows directly once body A has been taken.
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last |=> out_valid && out_data.last)
        else $error("body B did not follow body A");

    // The shared unit is never restarted while an operation is in flight.
    a_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
        u_req.start |-> !u_rsp.busy && !u_rsp.done)
        else $error("shared unit started while busy");

    // The block never takes a new item while a result is pending.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input accepted while a result is pending");

    // A second body without a held first body is dropped at once.
    a_orphan_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.command && !held_valid_reg |=> in_ready)
        else $error("orphan second body started work");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the sphere contact resolver with a scoreboard and random idling.

class contact_scoreboard;
    scr_pkg::item_out_t  expected_bodies[$];
    scr_pkg::item_in_t   held_body;
    bit                  held_ok;
    int                  errors;

    function logic [63:0] mag(longint a);
        return (a < 0) ? 64'(-a) : 64'(a);
    endfunction

    function logic [63:0] mul_q(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> sh;
        return (p > {64'd0, scr_pkg::CAP}) ? scr_pkg::CAP : p[63:0];
    endfunction

    function longint smul_q(longint a, longint b);
        logic [63:0] r;
        r = mul_q(mag(a), mag(b), 16);
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function logic [63:0] div_q(logic [63:0] num, logic [63:0] den);
        logic [127:0] q;
        q = ({64'd0, num} << 16) / {64'd0, den};
        return (q > {64'd0, scr_pkg::CAP}) ? scr_pkg::CAP : q[63:0];
    endfunction

    function logic [63:0] root_floor(logic [127:0] s);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= s)
                r = c;
        end
        return r;
    endfunction

    function logic [31:0] clamp(longint x);
        if (x > 64'sh7fff_ffff)
            return 32'h7fff_ffff;
        if (x < -64'sh8000_0000)
            return 32'h8000_0000;
        return x[31:0];
    endfunction

    function void resolve_pair(scr_pkg::item_in_t ia, scr_pkg::item_in_t ib);
        longint      pa[3], pb[3], va[3], vb[3], d[3], n[3];
        logic [63:0] ima, imb, inv_sum, center_gap, q, e, jn;
        logic [127:0] len_sq;
        longint      pen, s, c, closing, j, t;
        scr_pkg::item_out_t ra, rb;
        pa = '{longint'(ia.pos_x), longint'(ia.pos_y), longint'(ia.pos_z)};
        pb = '{longint'(ib.pos_x), longint'(ib.pos_y), longint'(ib.pos_z)};
        va = '{longint'(ia.vel_x), longint'(ia.vel_y), longint'(ia.vel_z)};
        vb = '{longint'(ib.vel_x), longint'(ib.vel_y), longint'(ib.vel_z)};
        ima = 64'(ia.inv_mass);
        imb = 64'(ib.inv_mass);
        inv_sum = ima + imb;
        len_sq = '0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = pa[i] - pb[i];
            len_sq += {64'd0, mag(d[i])} * {64'd0, mag(d[i])};
        end
        // Coincident centers or two immovable bodies leave everything as it came in.
        if (len_sq != 0 && inv_sum != 0)
        begin
            center_gap = root_floor(len_sq);
            for (int i = 0; i < 3; i++)
            begin
                q = div_q(mag(d[i]), center_gap);
                n[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
            end
            pen = longint'(64'(ia.radius) + 64'(ib.radius)) - longint'(center_gap);
            if (pen > 0)
            begin
                s = longint'(div_q(64'(pen), inv_sum));
                for (int i = 0; i < 3; i++)
                begin
                    c = smul_q(n[i], s);
                    pa[i] += smul_q(c, longint'(ima));
                    pb[i] -= smul_q(c, longint'(imb));
                end
            end
            closing = 0;
            for (int i = 0; i < 3; i++)
                closing += smul_q(va[i] - vb[i], n[i]);
            if (closing < 0)
            begin
                e = (ia.restitution > ib.restitution) ? 64'(ia.restitution)
                                                      : 64'(ib.restitution);
                jn = mul_q(mag(closing), 64'd65536 + e, 16);
                j = longint'(div_q(jn, inv_sum));
                for (int i = 0; i < 3; i++)
                begin
                    t = smul_q(n[i], j);
                    va[i] += smul_q(t, longint'(ima));
                    vb[i] -= smul_q(t, longint'(imb));
                end
            end
        end
        ra = '{1'b0, clamp(pa[0]), clamp(pa[1]), clamp(pa[2]),
               clamp(va[0]), clamp(va[1]), clamp(va[2]), 1'b0};
        rb = '{1'b1, clamp(pb[0]), clamp(pb[1]), clamp(pb[2]),
               clamp(vb[0]), clamp(vb[1]), clamp(vb[2]), 1'b1};
        expected_bodies = {expected_bodies, ra, rb};
    endfunction

    function void note_input(scr_pkg::item_in_t it);
        if (!it.command)
        begin
            held_body = it;
            held_ok = 1'b1;
        end
        else if (held_ok)
        begin
            held_ok = 1'b0;
            resolve_pair(held_body, it);
        end
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    function void check_result(scr_pkg::item_out_t got);
        scr_pkg::item_out_t want;
        if (expected_bodies.size() == 0)
        begin
            $error("result item with nothing expected");
            errors++;
            return;
        end
        want = expected_bodies.pop_front();
        check_field("body_slot", 32'(want.body_slot), 32'(got.body_slot));
        check_field("new_pos_x", want.new_pos_x, got.new_pos_x);
        check_field("new_pos_y", want.new_pos_y, got.new_pos_y);
        check_field("new_pos_z", want.new_pos_z, got.new_pos_z);
        check_field("new_vel_x", want.new_vel_x, got.new_vel_x);
        check_field("new_vel_y", want.new_vel_y, got.new_vel_y);
        check_field("new_vel_z", want.new_vel_z, got.new_vel_z);
        check_field("last", 32'(want.last), 32'(got.last));
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;
    localparam int   ITEM_TARGET = 1700;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    scr_pkg::item_in_t  in_data;
    logic               out_valid;
    logic               out_ready;
    scr_pkg::item_out_t out_data;

    contact_scoreboard sb;
    bit  no_idle;
    int  items_sent;

    sphere_contact_resolve u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #150ms;
        $display("testbench: FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_input(in_data);
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    function automatic int gap_len();
        if (no_idle)
            return 0;
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    // The receiver stalls in bursts, and never stalls while no_idle is set.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = gap_len();
            end
        end
    end

    // Valid stays up into the next item when there is no gap, so each falling
    // edge sees a single drive of in_valid.
    task automatic send(scr_pkg::item_in_t it);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        @(negedge clk);
    endtask

    function automatic logic [31:0] near(logic [31:0] base, int span);
        return base + 32'($urandom_range(0, 2 * span)) - 32'(span);
    endfunction

    function automatic logic [31:0] pick_mass();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return $urandom;
            default: return $urandom_range(1, 32'h0002_0000);
        endcase
    endfunction

    function automatic scr_pkg::item_in_t wild_body(logic cmd);
        scr_pkg::item_in_t it;
        it = '{cmd, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, 17'($urandom)};
        return it;
    endfunction

    // A body close to the given center, so that contact and approach are common.
    function automatic scr_pkg::item_in_t near_body(logic cmd, logic [31:0] cx,
                                                    logic [31:0] cy, logic [31:0] cz);
        scr_pkg::item_in_t it;
        it.command     = cmd;
        it.pos_x       = near(cx, 32'h0002_0000);
        it.pos_y       = near(cy, 32'h0002_0000);
        it.pos_z       = near(cz, 32'h0002_0000);
        it.vel_x       = near(32'd0, 32'h0004_0000);
        it.vel_y       = near(32'd0, 32'h0004_0000);
        it.vel_z       = near(32'd0, 32'h0004_0000);
        it.inv_mass    = pick_mass();
        it.radius      = $urandom_range(0, 32'h0003_0000);
        it.restitution = ($urandom_range(0, 3) == 0) ? 17'($urandom)
                                                     : 17'($urandom_range(0, 65536));
        return it;
    endfunction

    task automatic random_pair();
        logic [31:0]       cx, cy, cz;
        scr_pkg::item_in_t a, b;
        cx = $urandom;
        cy = $urandom;
        cz = $urandom;
        if ($urandom_range(0, 4) == 0)
        begin
            a = wild_body(CMD_LOAD);
            b = wild_body(CMD_RESOLVE);
        end
        else
        begin
            a = near_body(CMD_LOAD, cx, cy, cz);
            b = near_body(CMD_RESOLVE, cx, cy, cz);
            if ($urandom_range(0, 15) == 0)
            begin
                b.pos_x = a.pos_x;
                b.pos_y = a.pos_y;
                b.pos_z = a.pos_z;
            end
        end
        send(a);
        send(b);
    endtask

    task automatic directed();
        scr_pkg::item_in_t a, b;
        // A resolve with no body held is dropped.
        send(wild_body(CMD_RESOLVE));
        // Overlapping, separating pair with ordinary masses.
        a = '{CMD_LOAD, 32'h0001_0000, 32'd0, 32'd0, -32'sh0002_0000, 32'd0, 32'd0,
              32'h0001_0000, 32'h0001_0000, 17'd32768};
        b = '{CMD_RESOLVE, 32'h0002_8000, 32'd0, 32'd0, 32'sh0001_0000, 32'd0, 32'd0,
              32'h0002_0000, 32'h0001_0000, 17'd0};
        send(a);
        send(b);
        // Same pair separating leaves the velocities alone.
        b.vel_x = 32'sh0004_0000;
        send(a);
        send(b);
        // Coincident centers.
        b = a;
        b.command = CMD_RESOLVE;
        send(a);
        send(b);
        // Both immovable.
        a.inv_mass = '0;
        b.inv_mass = '0;
        b.pos_x = 32'h0001_8000;
        send(a);
        send(b);
        // A repeated load replaces the held body; restitution above one.
        send(wild_body(CMD_LOAD));
        a = '{CMD_LOAD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff, 17'h1ffff};
        b = '{CMD_RESOLVE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff, 17'h1ffff};
        send(a);
        send(b);
        // Extreme masses with a small gap and a fast approach.
        a = '{CMD_LOAD, 32'd0, 32'd0, 32'd0, 32'h7fff_ffff, 32'd0, 32'd0,
              32'hffff_ffff, 32'hffff_ffff, 17'd65536};
        b = '{CMD_RESOLVE, 32'd1, 32'd0, 32'd0, 32'h8000_0000, 32'd0, 32'd0,
              32'd1, 32'd0, 17'd0};
        send(a);
        send(b);
        // One body immovable, the other light, along a diagonal.
        a = '{CMD_LOAD, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0, 32'd0,
              32'd0, 32'h0002_0000, 17'd65535};
        b = '{CMD_RESOLVE, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000,
              32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 17'd1};
        send(a);
        send(b);
    endtask

    initial
    begin
        int waited;
        sb = new();
        no_idle = 1'b0;
        items_sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed();
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 49) == 0)
                no_idle = ~no_idle;
            case ($urandom_range(0, 19))
                0: send(wild_body(CMD_RESOLVE));
                1: send(wild_body(CMD_LOAD));
                default: random_pair();
            endcase
        end
        in_valid <= 1'b0;

        waited = 0;
        while (sb.expected_bodies.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (3000) @(posedge clk);
        if (sb.errors == 0 && sb.expected_bodies.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule

/* files.f */
rtl/scr_pkg.sv
rtl/scr_arith_unit.sv
rtl/sphere_contact_resolve.sv
tb/testbench.sv
